@@ design/assert_macros.svh @@
// Assertion macros used by the line rasteriser controller.
// Simulation builds get concurrent assertions; synthesis builds get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Plain property, checked at every rising clock edge outside reset.
`define DDA_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("dda assertion failed");

// Antecedent in one cycle, consequent required in the next.
`define DDA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dda assertion failed");

`else

`define DDA_ASSERT(lbl, clk, rst_n, prop)
`define DDA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ design/dda_pkg.sv @@
// Shared types and constants of the DDA line rasteriser.
// Used by the controller, the datapath and the top level; depends on nothing.
package dda_pkg;

  localparam int unsigned DIM_BITS     = 11;
  localparam int unsigned COLOR_BITS   = 32;
  localparam int unsigned CFG_IDX_BITS = 1;

  localparam logic [DIM_BITS-1:0] FRAME_WIDTH_RST  = 11'd800;
  localparam logic [DIM_BITS-1:0] FRAME_HEIGHT_RST = 11'd600;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_HEIGHT = 1'b1;

  // Request action code that starts a new line.
  localparam logic ACT_START = 1'b0;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take_start;
    logic take_adv;
    logic div_go;
    logic load_step;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic req_start;
    logic start_zero;
    logic line_active;
    logic div_done;
  } sts_t;

endpackage

@@ design/dda_stream_if.sv @@
// Valid/ready channel interfaces for the rasteriser requests and pixel results.
// Depends on dda_pkg for the colour width.
interface dda_in_if #(
  parameter int unsigned COORD_BITS = 12
);
  logic                              valid;
  logic                              ready;
  logic                              action;
  logic signed [COORD_BITS-1:0]      start_x;
  logic signed [COORD_BITS-1:0]      start_y;
  logic signed [COORD_BITS-1:0]      end_x;
  logic signed [COORD_BITS-1:0]      end_y;
  logic [dda_pkg::COLOR_BITS-1:0]    line_color;

  modport source (
    output valid, action, start_x, start_y, end_x, end_y, line_color,
    input  ready
  );
  modport sink (
    input  valid, action, start_x, start_y, end_x, end_y, line_color,
    output ready
  );
endinterface

interface dda_out_if #(
  parameter int unsigned COORD_BITS = 12
);
  logic                              valid;
  logic                              ready;
  logic signed [COORD_BITS-1:0]      pixel_x;
  logic signed [COORD_BITS-1:0]      pixel_y;
  logic [dda_pkg::COLOR_BITS-1:0]    pixel_color;
  logic                              inside_res;
  logic                              last;

  modport source (
    output valid, pixel_x, pixel_y, pixel_color, inside_res, last,
    input  ready
  );
  modport sink (
    input  valid, pixel_x, pixel_y, pixel_color, inside_res, last,
    output ready
  );
endinterface

@@ design/dda_divider.sv @@
// Two-lane restoring divider for the per-axis increments, one quotient bit a cycle.
// Standalone; instantiated by the datapath.
module dda_divider #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 go_i,
  input  logic [1:0][COORD_BITS-1:0]           mag_i,
  input  logic [COORD_BITS-1:0]                count_i,
  output logic                                 done_o,
  output logic [1:0][FRAC_BITS:0]              quot_o
);

  localparam int unsigned QW    = FRAC_BITS + 1;
  localparam int unsigned DW    = COORD_BITS + FRAC_BITS + 1;
  localparam int unsigned IterW = $clog2(QW + 1);

  logic [IterW-1:0]            cnt_q, cnt_d;
  logic                        done_q;
  logic [COORD_BITS-1:0]       div_q;
  logic [1:0][COORD_BITS-1:0]  rem_q, rem_d;
  logic [1:0][QW-1:0]          sh_q, sh_d;
  logic [1:0][DW-1:0]          dividend;
  logic [1:0][COORD_BITS:0]    trial;
  logic [1:0][COORD_BITS:0]    diff;
  logic [1:0]                  ge;
  logic                        busy;

  assign busy = cnt_q != '0;

  // The quotient is known to stay below 2^(FRAC_BITS+1), so the top of the
  // dividend already sits below the divisor and only QW steps are needed.
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      dividend[l] = {1'b0, mag_i[l], {FRAC_BITS{1'b0}}} + DW'(count_i >> 1);
      trial[l]    = {rem_q[l], sh_q[l][QW-1]};
      diff[l]     = trial[l] - {1'b0, div_q};
      ge[l]       = trial[l] >= {1'b0, div_q};
      if (go_i) begin
        rem_d[l] = dividend[l][DW-1:QW];
        sh_d[l]  = dividend[l][QW-1:0];
      end else if (busy) begin
        rem_d[l] = ge[l] ? diff[l][COORD_BITS-1:0] : trial[l][COORD_BITS-1:0];
        sh_d[l]  = {sh_q[l][QW-2:0], ge[l]};
      end else begin
        rem_d[l] = rem_q[l];
        sh_d[l]  = sh_q[l];
      end
    end
  end

  always_comb begin
    if (go_i) begin
      cnt_d = IterW'(QW);
    end else if (busy) begin
      cnt_d = cnt_q - IterW'(1);
    end else begin
      cnt_d = cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= busy && (cnt_q == IterW'(1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      div_q <= count_i;
    end
    rem_q <= rem_d;
    sh_q  <= sh_d;
  end

  assign done_o = done_q;
  assign quot_o = sh_q;

endmodule

@@ design/dda_datapath.sv @@
// Datapath of the rasteriser: window registers, accumulators, increments,
// rounding and the pixel output register. Depends on dda_pkg and dda_divider.
module dda_datapath #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  dda_pkg::cmd_t                        cmd_i,
  output dda_pkg::sts_t                        sts_o,
  input  logic                                 action_i,
  input  logic signed [COORD_BITS-1:0]         start_x_i,
  input  logic signed [COORD_BITS-1:0]         start_y_i,
  input  logic signed [COORD_BITS-1:0]         end_x_i,
  input  logic signed [COORD_BITS-1:0]         end_y_i,
  input  logic [dda_pkg::COLOR_BITS-1:0]       line_color_i,
  input  logic                                 cfg_we_i,
  input  logic [dda_pkg::CFG_IDX_BITS-1:0]     cfg_idx_i,
  input  logic [dda_pkg::DIM_BITS-1:0]         cfg_data_i,
  output logic signed [COORD_BITS-1:0]         pixel_x_o,
  output logic signed [COORD_BITS-1:0]         pixel_y_o,
  output logic [dda_pkg::COLOR_BITS-1:0]       pixel_color_o,
  output logic                                 inside_res_o,
  output logic                                 last_o
);

  localparam int unsigned AccW   = COORD_BITS + FRAC_BITS + 1;
  localparam int unsigned StepW  = FRAC_BITS + 2;
  localparam int unsigned QW     = FRAC_BITS + 1;
  localparam int unsigned DeltaW = COORD_BITS + 1;
  localparam int unsigned CmpW   = (COORD_BITS - 1 > dda_pkg::DIM_BITS) ?
                                   (COORD_BITS - 1) : dda_pkg::DIM_BITS;
  localparam logic [AccW-1:0] RoundHalf = AccW'(1) << (FRAC_BITS - 1);

  logic [dda_pkg::DIM_BITS-1:0]   frame_w_q, frame_h_q;
  logic [AccW-1:0]                acc_x_q, acc_y_q;
  logic [StepW-1:0]               step_x_q, step_y_q;
  logic                           neg_x_q, neg_y_q;
  logic [COORD_BITS-1:0]          pixels_left_q;
  logic [dda_pkg::COLOR_BITS-1:0] color_q;

  logic [COORD_BITS-1:0]          pix_x_q, pix_y_q;
  logic [dda_pkg::COLOR_BITS-1:0] pix_color_q;
  logic                           pix_inside_q, pix_last_q;

  logic [DeltaW-1:0]              dx, dy, dx_neg, dy_neg;
  logic [COORD_BITS-1:0]          mag_x, mag_y, count;
  logic [1:0][QW-1:0]             quot;
  logic                           div_done;
  logic [StepW-1:0]               q_x_ext, q_y_ext;
  logic [COORD_BITS-1:0]          px_c, py_c;
  logic                           inside_c;

  function automatic logic [COORD_BITS-1:0] round_coord(input logic [AccW-1:0] acc);
    logic [AccW-1:0]       mag;
    logic [AccW-1:0]       sum;
    logic [COORD_BITS:0]   r;
    logic [COORD_BITS-1:0] v;
    mag = acc[AccW-1] ? (~acc + AccW'(1)) : acc;
    sum = mag + RoundHalf;
    r   = sum[AccW-1:FRAC_BITS];
    if (!acc[AccW-1]) begin
      if (r[COORD_BITS] || r[COORD_BITS-1]) begin
        v = {1'b0, {(COORD_BITS-1){1'b1}}};
      end else begin
        v = r[COORD_BITS-1:0];
      end
    end else begin
      // Magnitudes beyond 2^(COORD_BITS-1) clip to the most negative code.
      if (r[COORD_BITS] || (r[COORD_BITS-1] && (r[COORD_BITS-2:0] != '0))) begin
        v = {1'b1, {(COORD_BITS-1){1'b0}}};
      end else begin
        v = ~r[COORD_BITS-1:0] + COORD_BITS'(1);
      end
    end
    return v;
  endfunction

  // Start request: deltas, magnitudes and the step count.
  assign dx     = {end_x_i[COORD_BITS-1], end_x_i} - {start_x_i[COORD_BITS-1], start_x_i};
  assign dy     = {end_y_i[COORD_BITS-1], end_y_i} - {start_y_i[COORD_BITS-1], start_y_i};
  assign dx_neg = ~dx + DeltaW'(1);
  assign dy_neg = ~dy + DeltaW'(1);
  assign mag_x  = dx[DeltaW-1] ? dx_neg[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
  assign mag_y  = dy[DeltaW-1] ? dy_neg[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
  assign count  = (mag_x >= mag_y) ? mag_x : mag_y;

  dda_divider #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .go_i    (cmd_i.div_go),
    .mag_i   ({mag_y, mag_x}),
    .count_i (count),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  assign q_x_ext = {1'b0, quot[0]};
  assign q_y_ext = {1'b0, quot[1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_w_q     <= dda_pkg::FRAME_WIDTH_RST;
      frame_h_q     <= dda_pkg::FRAME_HEIGHT_RST;
      pixels_left_q <= '0;
    end else begin
      if (cfg_we_i && (cfg_idx_i == dda_pkg::CFG_FRAME_WIDTH)) begin
        frame_w_q <= cfg_data_i;
      end
      if (cfg_we_i && (cfg_idx_i == dda_pkg::CFG_FRAME_HEIGHT)) begin
        frame_h_q <= cfg_data_i;
      end
      if (cmd_i.take_start) begin
        pixels_left_q <= count;
      end else if (cmd_i.take_adv) begin
        pixels_left_q <= pixels_left_q - COORD_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_start) begin
      acc_x_q  <= {start_x_i[COORD_BITS-1], start_x_i, {FRAC_BITS{1'b0}}};
      acc_y_q  <= {start_y_i[COORD_BITS-1], start_y_i, {FRAC_BITS{1'b0}}};
      step_x_q <= '0;
      step_y_q <= '0;
      neg_x_q  <= dx[DeltaW-1];
      neg_y_q  <= dy[DeltaW-1];
      color_q  <= line_color_i;
    end else if (cmd_i.take_adv) begin
      acc_x_q <= acc_x_q + {{(AccW-StepW){step_x_q[StepW-1]}}, step_x_q};
      acc_y_q <= acc_y_q + {{(AccW-StepW){step_y_q[StepW-1]}}, step_y_q};
    end else if (cmd_i.load_step) begin
      step_x_q <= neg_x_q ? (~q_x_ext + StepW'(1)) : q_x_ext;
      step_y_q <= neg_y_q ? (~q_y_ext + StepW'(1)) : q_y_ext;
    end
  end

  // Rounding and window test are combinational on the registered accumulators.
  assign px_c     = round_coord(acc_x_q);
  assign py_c     = round_coord(acc_y_q);
  assign inside_c = !px_c[COORD_BITS-1] && !py_c[COORD_BITS-1] &&
                    (CmpW'(px_c[COORD_BITS-2:0]) < CmpW'(frame_w_q)) &&
                    (CmpW'(py_c[COORD_BITS-2:0]) < CmpW'(frame_h_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      pix_x_q      <= px_c;
      pix_y_q      <= py_c;
      pix_color_q  <= color_q;
      pix_inside_q <= inside_c;
      pix_last_q   <= pixels_left_q == '0;
    end
  end

  assign pixel_x_o     = pix_x_q;
  assign pixel_y_o     = pix_y_q;
  assign pixel_color_o = pix_color_q;
  assign inside_res_o  = pix_inside_q;
  assign last_o        = pix_last_q;

  assign sts_o.req_start   = action_i == dda_pkg::ACT_START;
  assign sts_o.start_zero  = count == '0;
  assign sts_o.line_active = pixels_left_q != '0;
  assign sts_o.div_done    = div_done;

endmodule

@@ design/dda_ctrl.sv @@
// Controller of the rasteriser: request handshake, sequencing and output valid.
// Depends on dda_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dda_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  dda_pkg::sts_t sts_i,
  output dda_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_EMIT = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_fire;
  logic   out_free;

  assign in_ready_o = state_q == S_IDLE;
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  assign cmd_o.take_start = in_fire && sts_i.req_start;
  assign cmd_o.take_adv   = in_fire && !sts_i.req_start && sts_i.line_active;
  assign cmd_o.div_go     = cmd_o.take_start && !sts_i.start_zero;
  assign cmd_o.load_step  = (state_q == S_DIV) && sts_i.div_done;
  assign cmd_o.load_out   = (state_q == S_EMIT) && out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_o.take_start) begin
          state_d = sts_i.start_zero ? S_EMIT : S_DIV;
        end else if (cmd_o.take_adv) begin
          state_d = S_EMIT;
        end
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `DDA_ASSERT_NEXT(a_div_holds, clk_i, rst_ni, (state_q == S_DIV) && !sts_i.div_done, state_q == S_DIV)
  `DDA_ASSERT(a_load_out_free, clk_i, rst_ni, !cmd_o.load_out || !out_valid_q || out_ready_i)
  `DDA_ASSERT_NEXT(a_start_divides, clk_i, rst_ni, in_fire && sts_i.req_start && !sts_i.start_zero, state_q == S_DIV)
  `DDA_ASSERT_NEXT(a_idle_advance_dropped, clk_i, rst_ni, in_fire && !sts_i.req_start && !sts_i.line_active, state_q == S_IDLE)

endmodule

@@ design/dda_line_rasterizer.sv @@
// Top level of the DDA line rasteriser: controller plus datapath.
// Depends on dda_pkg, dda_stream_if, dda_ctrl and dda_datapath.
//
// Usage: requests arrive on in_i (valid/ready). A start request (action 0)
// loads both endpoints and the colour; an advance request (action 1) steps
// the active line by one pixel. Pixels leave on out_o as one result per
// request, each with the window flag, and the last flag is set on the final pixel.
// An advance while no line is active is taken and gives no pixel.
// Sequencing: an advance, or a start of a zero-length line, goes from idle
// straight to the emit state; a start of a longer line first runs the two-lane
// increment divider, one quotient bit a cycle, and then emits its first pixel.
// A new request is taken only once the pending pixel is in the output register.
// The pixel sits in an output register; while the receiver stalls the next
// request is still taken and its pixel waits until the register is free.
// Reset clears the line state and sets the window to 800 by 600; the
// configuration port writes the window size, index 0 width and 1 height.
module dda_line_rasterizer #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  dda_in_if.sink                           in_i,
  dda_out_if.source                        out_o,
  input  logic                             cfg_we_i,
  input  logic [dda_pkg::CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [dda_pkg::DIM_BITS-1:0]     cfg_data_i
);

  dda_pkg::cmd_t cmd;
  dda_pkg::sts_t sts;
  logic          in_ready;
  logic          out_valid;

  dda_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  dda_datapath #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .action_i      (in_i.action),
    .start_x_i     (in_i.start_x),
    .start_y_i     (in_i.start_y),
    .end_x_i       (in_i.end_x),
    .end_y_i       (in_i.end_y),
    .line_color_i  (in_i.line_color),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .pixel_x_o     (out_o.pixel_x),
    .pixel_y_o     (out_o.pixel_y),
    .pixel_color_o (out_o.pixel_color),
    .inside_res_o  (out_o.inside_res),
    .last_o        (out_o.last)
  );

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;

endmodule
